[src/tagged_rgba_color_op_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tagged RGBA color operation unit
// Shared wrappers that clock assertions on clk and report through $error.
// ----------------------------------------------------------------------------
`ifndef TAGGED_RGBA_COLOR_OP_UNIT_MACROS_SVH
`define TAGGED_RGBA_COLOR_OP_UNIT_MACROS_SVH

// Checked only outside reset.
`define TRCO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define TRCO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/trco_pkg.sv]
// ----------------------------------------------------------------------------
// trco_pkg
// Types and constants shared by the stages of the color operation unit.
// ----------------------------------------------------------------------------
package trco_pkg;

  localparam int COLOR_W = 57;
  localparam int TAG_POS = 56;

  localparam logic [6:0] AMOUNT_MAX = 7'd100;
  localparam logic [7:0] BYTE_MAX   = 8'hFF;

  localparam logic [9:0] GRAY_W_R = 10'd299;
  localparam logic [9:0] GRAY_W_G = 10'd587;
  localparam logic [9:0] GRAY_W_B = 10'd114;

  // floor(m / 100) = (m * 5243) >> 19 for m below 43690.
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int          RECIP_100_SHIFT = 19;
  // floor(s / 1000) = (s * 268436) >> 28 for s below 493447.
  localparam logic [18:0] RECIP_1000       = 19'd268436;
  localparam int          RECIP_1000_SHIFT = 28;

  typedef enum logic [2:0] {
    CMD_LERP     = 3'd0,
    CMD_BRIGHTEN = 3'd1,
    CMD_DARKEN   = 3'd2,
    CMD_GRAY     = 3'd3,
    CMD_INVERT   = 3'd4,
    CMD_NONE     = 3'd7
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 tag_on;
    logic [3:0][7:0]      base;
    logic [3:0]           neg;
    logic [3:0][14:0]     prod;
    logic [17:0]          gray_sum;
  } prep_t;

  typedef struct packed {
    op_t                  op;
    logic                 tag_on;
    logic [3:0][7:0]      base;
    logic [3:0]           neg;
    logic [3:0][7:0]      quot;
    logic [7:0]           gray;
  } scale_t;

endpackage

[src/trco_prep.sv]
// ----------------------------------------------------------------------------
// trco_prep
// First stage: decodes the opcode, clamps the amount and forms the
// per-channel products and the weighted luminance sum.
// ----------------------------------------------------------------------------
module trco_prep import trco_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0]           cmd,
  input  logic [COLOR_W-1:0]   color_a,
  input  logic [COLOR_W-1:0]   color_b,
  input  logic signed [7:0]    amount,
  output logic                 out_valid,
  output prep_t                out_data
);

  prep_t           data_next;
  logic [6:0]      t;
  logic [3:0][7:0] xa;
  logic [3:0][7:0] xb;
  logic [3:0][8:0] diff;
  logic [3:0][7:0] mag;

  always_comb begin
    if (amount[7]) begin
      t = 7'd0;
    end else if (amount[6:0] > AMOUNT_MAX) begin
      t = AMOUNT_MAX;
    end else begin
      t = amount[6:0];
    end
  end

  assign xa[0] = color_a[7:0];
  assign xa[1] = color_a[15:8];
  assign xa[2] = color_a[23:16];
  assign xa[3] = color_a[TAG_POS] ? color_a[31:24] : BYTE_MAX;
  assign xb[0] = color_b[7:0];
  assign xb[1] = color_b[15:8];
  assign xb[2] = color_b[23:16];
  assign xb[3] = color_b[TAG_POS] ? color_b[31:24] : BYTE_MAX;

  always_comb begin
    data_next.op       = CMD_NONE;
    data_next.tag_on   = color_a[TAG_POS];
    data_next.base     = xa;
    data_next.neg      = '0;
    data_next.gray_sum = 18'(xa[2] * GRAY_W_R) + 18'(xa[1] * GRAY_W_G)
                       + 18'(xa[0] * GRAY_W_B);
    for (int i = 0; i < 4; i++) begin
      diff[i] = {1'b0, xb[i]} - {1'b0, xa[i]};
      mag[i]  = 8'd0;
    end
    case (cmd)
      CMD_LERP: begin
        data_next.op     = CMD_LERP;
        data_next.tag_on = color_a[TAG_POS] | color_b[TAG_POS];
        for (int i = 0; i < 4; i++) begin
          data_next.neg[i] = diff[i][8];
          mag[i] = diff[i][8] ? 8'(-diff[i]) : diff[i][7:0];
        end
      end
      CMD_BRIGHTEN: begin
        data_next.op = CMD_BRIGHTEN;
        for (int i = 0; i < 3; i++) begin
          mag[i] = BYTE_MAX - xa[i];
        end
      end
      CMD_DARKEN: begin
        data_next.op = CMD_DARKEN;
        for (int i = 0; i < 3; i++) begin
          data_next.neg[i] = 1'b1;
          mag[i] = xa[i];
        end
      end
      CMD_GRAY: begin
        data_next.op = CMD_GRAY;
      end
      CMD_INVERT: begin
        data_next.op = CMD_INVERT;
        for (int i = 0; i < 3; i++) begin
          data_next.base[i] = BYTE_MAX - xa[i];
        end
      end
      default: begin
        data_next.op = CMD_NONE;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      data_next.prod[i] = 15'(mag[i] * t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

[src/trco_scale.sv]
// ----------------------------------------------------------------------------
// trco_scale
// Second stage: divides the channel products by 100 and the luminance sum
// by 1000 through reciprocal multiplication.
// ----------------------------------------------------------------------------
module trco_scale import trco_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  prep_t   in_data,
  output logic    out_valid,
  output scale_t  out_data
);

  scale_t           data_next;
  logic [3:0][27:0] quot_full;
  logic [36:0]      gray_full;

  always_comb begin
    data_next.op     = in_data.op;
    data_next.tag_on = in_data.tag_on;
    data_next.base   = in_data.base;
    data_next.neg    = in_data.neg;
    for (int i = 0; i < 4; i++) begin
      quot_full[i]      = in_data.prod[i] * RECIP_100;
      data_next.quot[i] = quot_full[i][RECIP_100_SHIFT +: 8];
    end
    gray_full      = in_data.gray_sum * RECIP_1000;
    data_next.gray = gray_full[RECIP_1000_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

[src/trco_pack.sv]
// ----------------------------------------------------------------------------
// trco_pack
// Third stage: applies the scaled adjustment to each channel, or the gray
// level, and packs the result color into the output register.
// ----------------------------------------------------------------------------
module trco_pack import trco_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  scale_t               in_data,
  output logic                 out_valid,
  output logic [63:0]          out_color
);

  logic [3:0][7:0] chan;
  logic [63:0]     color_next;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chan[i] = in_data.neg[i] ? in_data.base[i] - in_data.quot[i]
                               : in_data.base[i] + in_data.quot[i];
    end
    if (in_data.op == CMD_GRAY) begin
      for (int i = 0; i < 3; i++) begin
        chan[i] = in_data.gray;
      end
    end
    color_next = {40'd0, chan[2], chan[1], chan[0]};
    if (in_data.tag_on) begin
      color_next[31:24]   = chan[3];
      color_next[TAG_POS] = 1'b1;
    end
    if (in_data.op == CMD_NONE) begin
      color_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_color <= color_next;
    end
  end

endmodule

[src/tagged_rgba_color_op_unit.sv]
// Pipeline: input acceptance to m_axis_tvalid passes through the three register
// stages (decode and products, reciprocal division, adjust and pack).
// Throughput: one item per cycle unless stalled; each stage advances when the one
// after it is empty or moving, so a stall holds every item in place without loss.
// Reset: synchronous rst clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// tagged_rgba_color_op_unit
// Stateless per-pixel color operations on packed RGB colors with optional alpha.
// ----------------------------------------------------------------------------
`include "tagged_rgba_color_op_unit_macros.svh"

module tagged_rgba_color_op_unit import trco_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // color_a [56:0], color_b [113:57], amount [121:114], zero [127:122]
  input  logic [127:0]  s_axis_tdata,
  // cmd [2:0]
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // result_color [56:0], zero [63:57]
  output logic [63:0]   m_axis_tdata
);

  logic   en1;
  logic   en2;
  logic   en3;
  logic   v1;
  logic   v2;
  prep_t  d1;
  scale_t d2;

  assign en3 = !m_axis_tvalid || m_axis_tready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  trco_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en1),
    .in_valid  (s_axis_tvalid),
    .cmd       (s_axis_tuser),
    .color_a   (s_axis_tdata[56:0]),
    .color_b   (s_axis_tdata[113:57]),
    .amount    (s_axis_tdata[121:114]),
    .out_valid (v1),
    .out_data  (d1)
  );

  trco_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en2),
    .in_valid  (v1),
    .in_data   (d1),
    .out_valid (v2),
    .out_data  (d2)
  );

  trco_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .en        (en3),
    .in_valid  (v2),
    .in_data   (d2),
    .out_valid (m_axis_tvalid),
    .out_color (m_axis_tdata)
  );

  `TRCO_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")
  `TRCO_ASSERT(a_ready_follows, m_axis_tready |-> s_axis_tready,
               "input stalled while output drains")
  `TRCO_ASSERT(a_latency,
               (s_axis_tvalid && s_axis_tready && m_axis_tready)
               ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid,
               "item did not reach output in three cycles")
  `TRCO_ASSERT(a_untagged_zero,
               (m_axis_tvalid && !m_axis_tdata[TAG_POS]) |-> (m_axis_tdata[63:24] == 40'd0),
               "untagged result carries upper bits")

endmodule
